@@ rtl/stfl_pkg.sv @@
`timescale 1ns / 1ps

package stfl_pkg;

    localparam int TABLE_DEPTH = 1024;
    localparam int ADDR_W      = $clog2(TABLE_DEPTH);
    localparam int CNT_W       = ADDR_W + 1;
    localparam int SRCH_W      = CNT_W + 1;
    localparam int VALUE_W     = 32;
    localparam int POS_W       = 10;

    typedef enum logic [1:0] {
        MODE_CLEAR  = 2'd0,
        MODE_APPEND = 2'd1,
        MODE_FIRST  = 2'd2,
        MODE_LAST   = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_FULL      = 2'd2
    } status_t;

    typedef struct packed {
        logic load;
        logic probe;
        logic cmp;
        logic out_load;
    } dp_cmd_t;

    typedef struct packed {
        logic range_ok;
    } dp_sts_t;

endpackage

@@ rtl/stfl_dp.sv @@
`timescale 1ns / 1ps

module stfl_dp (
    input  logic                                clk,
    input  logic                                rst_n,
    input  stfl_pkg::dp_cmd_t                   cmd,
    output stfl_pkg::dp_sts_t                   sts,
    input  stfl_pkg::mode_t                     mode,
    input  logic signed [stfl_pkg::VALUE_W-1:0] value,
    output stfl_pkg::status_t                   status,
    output logic [stfl_pkg::POS_W-1:0]          position
);
    import stfl_pkg::*;

    logic [VALUE_W-1:0]        mem [TABLE_DEPTH];
    logic [VALUE_W-1:0]        rd_q;

    logic [CNT_W-1:0]          count_reg;
    logic                      full_reg;
    mode_t                     mode_reg;
    logic signed [VALUE_W-1:0] key_reg;
    logic [CNT_W-1:0]          low_reg;
    logic signed [SRCH_W-1:0]  high_reg;
    logic [ADDR_W-1:0]         mid_reg;
    logic [ADDR_W-1:0]         hit_reg;
    logic                      found_reg;
    status_t                   status_reg;
    logic [POS_W-1:0]          position_reg;

    logic signed [SRCH_W-1:0]  low_s;
    logic signed [SRCH_W-1:0]  sum;
    logic [ADDR_W-1:0]         mid;
    logic                      is_query;
    logic                      is_full;
    logic signed [VALUE_W-1:0] probe_val;

    assign low_s        = $signed({1'b0, low_reg});
    assign sum          = low_s + high_reg;
    assign mid          = sum[ADDR_W:1];
    assign sts.range_ok = (low_s <= high_reg);
    assign is_query     = (mode == MODE_FIRST) || (mode == MODE_LAST);
    assign is_full      = (count_reg == CNT_W'(TABLE_DEPTH));
    assign probe_val    = $signed(rd_q);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else if (cmd.load)
        begin
            if (mode == MODE_CLEAR)
            begin
                count_reg <= '0;
            end
            else if (mode == MODE_APPEND && !is_full)
            begin
                count_reg <= count_reg + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load && mode == MODE_APPEND && !is_full)
        begin
            mem[count_reg[ADDR_W-1:0]] <= value;
        end
        if (cmd.probe)
        begin
            rd_q <= mem[mid];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            mode_reg <= mode;
            key_reg  <= value;
            full_reg <= is_full;
            if (is_query)
            begin
                low_reg   <= '0;
                high_reg  <= $signed({1'b0, count_reg}) - SRCH_W'(1);
                found_reg <= 1'b0;
            end
        end
        if (cmd.probe)
        begin
            mid_reg <= mid;
        end
        if (cmd.cmp)
        begin
            if (probe_val == key_reg)
            begin
                found_reg <= 1'b1;
                hit_reg   <= mid_reg;
                if (mode_reg == MODE_LAST)
                begin
                    low_reg <= {1'b0, mid_reg} + CNT_W'(1);
                end
                else
                begin
                    high_reg <= $signed({2'b00, mid_reg}) - SRCH_W'(1);
                end
            end
            else if (probe_val < key_reg)
            begin
                low_reg <= {1'b0, mid_reg} + CNT_W'(1);
            end
            else
            begin
                high_reg <= $signed({2'b00, mid_reg}) - SRCH_W'(1);
            end
        end
        if (cmd.out_load)
        begin
            unique case (mode_reg)
                MODE_CLEAR:
                begin
                    status_reg   <= ST_OK;
                    position_reg <= '0;
                end
                MODE_APPEND:
                begin
                    status_reg   <= full_reg ? ST_FULL : ST_OK;
                    position_reg <= '0;
                end
                default:
                begin
                    status_reg   <= found_reg ? ST_OK : ST_NOT_FOUND;
                    position_reg <= found_reg ? POS_W'(hit_reg) : '0;
                end
            endcase
        end
    end

    assign status   = status_reg;
    assign position = position_reg;

`ifndef SYNTH
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(TABLE_DEPTH))
        else $error("element count above table depth");

    a_probe_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.probe && sts.range_ok |-> {1'b0, mid} < count_reg)
        else $error("probe outside occupied entries");

    a_clear_empties: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load && mode == MODE_CLEAR |=> count_reg == '0)
        else $error("clear did not empty table");
`endif

endmodule

@@ rtl/stfl_ctrl.sv @@
`timescale 1ns / 1ps

module stfl_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    output logic              req_stall,
    input  stfl_pkg::mode_t   mode,
    output logic              rsp_valid,
    input  logic              rsp_stall,
    output stfl_pkg::dp_cmd_t cmd,
    input  stfl_pkg::dp_sts_t sts
);
    import stfl_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_PROBE,
        S_CMP,
        S_FINISH
    } state_t;

    state_t state_reg;
    logic   rsp_valid_reg;
    logic   accept;
    logic   out_free;

    assign req_stall    = (state_reg != S_IDLE);
    assign accept       = req_valid && !req_stall;
    assign out_free     = !rsp_valid_reg || !rsp_stall;
    assign cmd.load     = accept;
    assign cmd.probe    = (state_reg == S_PROBE);
    assign cmd.cmp      = (state_reg == S_CMP);
    assign cmd.out_load = (state_reg == S_FINISH) && out_free;
    assign rsp_valid    = rsp_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            if (state_reg == S_FINISH && out_free)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp_valid_reg && !rsp_stall)
            begin
                rsp_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        if (mode == MODE_FIRST || mode == MODE_LAST)
                        begin
                            state_reg <= S_PROBE;
                        end
                        else
                        begin
                            state_reg <= S_FINISH;
                        end
                    end
                end
                S_PROBE:
                begin
                    state_reg <= sts.range_ok ? S_CMP : S_FINISH;
                end
                S_CMP:
                begin
                    state_reg <= S_PROBE;
                end
                S_FINISH:
                begin
                    if (out_free)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule

@@ rtl/sorted_table_first_last_search.sv @@
`timescale 1ns / 1ps

// channel   valid      stall      payload
// request   req_valid  req_stall  mode, value
// response  rsp_valid  rsp_stall  status, position
//
// Clear and append: idle, then finish, where the result is registered once the
// output register is free. Query: binary-search steps (table read, then compare)
// via the single table read port, then finish; requests are taken only in idle.
// Reset empties the table (count to zero); no clearing pass.
// A finished result waits in the output register while rsp_stall is high;
// the next request is taken meanwhile but its result waits behind it.

module sorted_table_first_last_search (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                req_valid,
    output logic                                req_stall,
    input  stfl_pkg::mode_t                     mode,
    input  logic signed [stfl_pkg::VALUE_W-1:0] value,
    output logic                                rsp_valid,
    input  logic                                rsp_stall,
    output stfl_pkg::status_t                   status,
    output logic [stfl_pkg::POS_W-1:0]          position
);
    import stfl_pkg::*;

    dp_cmd_t cmd;
    dp_sts_t sts;

    stfl_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .mode      (mode),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .cmd       (cmd),
        .sts       (sts)
    );

    stfl_dp u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .sts      (sts),
        .mode     (mode),
        .value    (value),
        .status   (status),
        .position (position)
    );

endmodule
